// ----- rtl/dvf_pkg.sv -----
// dvf_pkg: shared widths and types for the 32 by 16 divide block
// used by dvf_divider, dvf_fixup and divide_32_by_16_with_flags_core
`default_nettype none

package dvf_pkg;

  // operand and count widths
  localparam int unsigned DvdW = 32;
  localparam int unsigned DvsW = 16;
  localparam int unsigned QuoW = 16;
  localparam int unsigned CntW = $clog2(DvdW);

  // operation codes
  localparam logic OpUnsigned = 1'b0;
  localparam logic OpSigned   = 1'b1;

  // condition flags, n in the top bit
  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } dvf_flags_t;

  // per-item control carried from accept to result fix-up
  typedef struct packed {
    logic is_signed;
    logic dvd_neg;
    logic quo_neg;
    logic dz;
  } dvf_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/dvf_divider.sv -----
// dvf_divider: radix-2 restoring divider, one quotient bit per cycle
// magnitude operands only; depends on dvf_pkg
`default_nettype none

module dvf_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dvf_pkg::DvdW-1:0]  dividend_i,
  input  logic [dvf_pkg::DvsW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [dvf_pkg::DvdW-1:0]  quo_o,
  output logic [dvf_pkg::DvsW-1:0]  rem_o
);
  import dvf_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            fits;

  // one shift and trial subtract step
  always_comb begin
    trial = {rem_q, quo_q[DvdW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
  end

  // sequencer and datapath next state
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DvdW-2:0], fits};
      rem_d = fits ? diff[DvsW-1:0] : trial[DvsW-1:0];
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- rtl/dvf_fixup.sv -----
// dvf_fixup: sign fix-up, overflow check and flag update after a divide
// combinational; depends on dvf_pkg
`default_nettype none

module dvf_fixup (
  input  dvf_pkg::dvf_ctl_t         ctl_i,
  input  logic [dvf_pkg::DvdW-1:0]  dividend_i,
  input  logic [dvf_pkg::DvdW-1:0]  quo_i,
  input  logic [dvf_pkg::DvsW-1:0]  rem_i,
  input  dvf_pkg::dvf_flags_t       flags_i,
  output logic [dvf_pkg::DvdW-1:0]  result_o,
  output dvf_pkg::dvf_flags_t       flags_o
);
  import dvf_pkg::*;

  logic            ovf_u;
  logic            ovf_s;
  logic            ovf;
  logic [QuoW-1:0] quo16;
  logic [DvsW-1:0] rem16;

  // quotient range check
  always_comb begin
    ovf_u = |quo_i[DvdW-1:QuoW];
    ovf_s = ovf_u || (quo_i[QuoW-1] && (!ctl_i.quo_neg || (|quo_i[QuoW-2:0])));
    ovf   = (ctl_i.is_signed == OpSigned) ? ovf_s : ovf_u;
  end

  // restore signs
  always_comb begin
    quo16 = ctl_i.quo_neg ? (QuoW'(0) - quo_i[QuoW-1:0]) : quo_i[QuoW-1:0];
    rem16 = ctl_i.dvd_neg ? (DvsW'(0) - rem_i) : rem_i;
  end

  // result and flags
  always_comb begin
    result_o = dividend_i;
    flags_o  = flags_i;
    if (!ctl_i.dz) begin
      if (ovf) begin
        flags_o.v = 1'b1;
        flags_o.c = 1'b0;
      end else begin
        result_o  = {rem16, quo16};
        flags_o.n = quo16[QuoW-1];
        flags_o.z = (quo16 == '0);
        flags_o.v = 1'b0;
        flags_o.c = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/divide_32_by_16_with_flags_core.sv -----
// divide_32_by_16_with_flags_core: 32 by 16 divide with persistent N/Z/V/C flags
// depends on dvf_pkg, dvf_divider and dvf_fixup
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry operation_i (0 unsigned,
//   1 signed), dividend_i and divisor_i. Output channel: out_valid_o /
//   out_stall_i carry result_o (remainder high, quotient low), the four flags
//   and divide_by_zero_o. A beat moves when valid is high and stall is low.
//   Every input beat gives exactly one output beat.
//   One item is in work at a time, so the block takes no new beat until the
//   last result is loaded into the output register. The shift-subtract unit
//   produces one quotient bit per cycle over all 32 dividend bits; the sign
//   fix-up into the output register is combinational.
//   in_stall_o is high while an item is in work. If the receiver stalls, the
//   finished result waits in the output register; a next item may be taken
//   meanwhile, and its own result waits for the register to free up.
//   Reset clears the flags to zero and empties the block.
`default_nettype none

module divide_32_by_16_with_flags_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [dvf_pkg::DvdW-1:0]  dividend_i,
  input  logic [dvf_pkg::DvsW-1:0]  divisor_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dvf_pkg::DvdW-1:0]  result_o,
  output logic                      flag_n_o,
  output logic                      flag_z_o,
  output logic                      flag_v_o,
  output logic                      flag_c_o,
  output logic                      divide_by_zero_o
);
  import dvf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_HOLD
  } state_e;

  state_e          state_q, state_d;
  logic            in_accept;
  logic            out_free;
  logic            load_out;
  logic            dvd_neg, dvs_neg;
  logic [DvdW-1:0] dvd_mag;
  logic [DvsW-1:0] dvs_mag;
  dvf_ctl_t        ctl_in, ctl_q;
  logic [DvdW-1:0] dvd_q;
  dvf_flags_t      flags_q, flags_d;
  logic            div_done;
  logic [DvdW-1:0] div_quo;
  logic [DvsW-1:0] div_rem;
  logic [DvdW-1:0] fix_result;
  dvf_flags_t      fix_flags;
  logic            out_valid_q, out_valid_d;
  logic [DvdW-1:0] out_result_q;
  dvf_flags_t      out_flags_q;
  logic            out_dz_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // operand magnitudes and sign control
  always_comb begin
    dvd_neg = (operation_i == OpSigned) && dividend_i[DvdW-1];
    dvs_neg = (operation_i == OpSigned) && divisor_i[DvsW-1];
    dvd_mag = dvd_neg ? (DvdW'(0) - dividend_i) : dividend_i;
    dvs_mag = dvs_neg ? (DvsW'(0) - divisor_i) : divisor_i;
    ctl_in.is_signed = operation_i;
    ctl_in.dvd_neg   = dvd_neg;
    ctl_in.quo_neg   = dvd_neg ^ dvs_neg;
    ctl_in.dz        = (divisor_i == '0);
  end

  dvf_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .dividend_i (dvd_mag),
    .divisor_i  (dvs_mag),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  dvf_fixup u_fixup (
    .ctl_i      (ctl_q),
    .dividend_i (dvd_q),
    .quo_i      (div_quo),
    .rem_i      (div_rem),
    .flags_i    (flags_q),
    .result_o   (fix_result),
    .flags_o    (fix_flags)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (div_done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    flags_d     = load_out ? fix_flags : flags_q;
    out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // state, flags and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item payload and output beat registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ctl_q <= ctl_in;
      dvd_q <= dividend_i;
    end
    if (load_out) begin
      out_result_q <= fix_result;
      out_flags_q  <= fix_flags;
      out_dz_q     <= ctl_q.dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = out_result_q;
  assign flag_n_o         = out_flags_q.n;
  assign flag_z_o         = out_flags_q.z;
  assign flag_v_o         = out_flags_q.v;
  assign flag_c_o         = out_flags_q.c;
  assign divide_by_zero_o = out_dz_q;

  // the carry flag can never be set: reset clears it and every divide clears it
  assert property (@(posedge clk_i) disable iff (!rst_ni) !flags_q.c)
    else $error("carry flag set");

  // an accepted beat keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> in_stall_o)
    else $error("input not stalled after accept");

  // the divider only finishes while an item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_done |-> (state_q == S_BUSY))
    else $error("divider done outside busy state");

  // a good divide reports Z exactly for a zero quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !divide_by_zero_o && !flag_v_o) |->
      (flag_z_o == (result_o[QuoW-1:0] == '0)))
    else $error("zero flag disagrees with quotient");

endmodule

`default_nettype wire
